// ===== rtl/prmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmf_pkg
// Shared sizes, result codes, datapath command and status types for the
// push-relabel maximum flow engine.
// ----------------------------------------------------------------------------
package prmf_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_AW   = 6;
  localparam int ARC_SLOTS = 512;
  localparam int ARC_AW    = 9;
  localparam int ARC_CW    = 10;
  localparam int CAP_W     = 16;
  localparam int FLOW_W    = 17;
  localparam int EXC_W     = 24;
  localparam int HGT_W     = 8;
  localparam int NC_W      = 7;

  localparam logic [ARC_CW-1:0] ARC_NONE = ARC_CW'(ARC_SLOTS);
  localparam logic [NC_W-1:0]   NC_MIN   = NC_W'(2);
  localparam logic [NC_W-1:0]   NC_MAX   = NC_W'(MAX_NODES);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH,
    OP_ADD_RDU, OP_ADD_WRA, OP_ADD_RDV, OP_ADD_WRB,
    OP_CLR, OP_SRC_H, OP_LOAD_A, OP_ARC_RD, OP_SRC_EVAL, OP_SRC_REV, OP_A_NEXT,
    OP_POP_RD, OP_POP_U, OP_LOAD_U, OP_U_DONE,
    OP_CUR_RD, OP_D_H, OP_PUSH1, OP_PUSH2, OP_ADV,
    OP_RL_FIRST, OP_RL_H, OP_RL_EVAL, OP_RL_END,
    OP_FIN_RD, OP_OUT_OK, OP_OUT_BAD, OP_OUT_FULL, OP_OUT_FLOW
  } dp_op_t;

  typedef struct packed {
    logic is_solve;
    logic bad_node;
    logic table_full;
    logic st_same;
    logic clr_last;
    logic a_end;
    logic sat_ok;
    logic q_empty;
    logic pop_skip;
    logic exc_zero;
    logic cur_end;
    logic push_ok;
    logic rl_res;
  } dp_stat_t;

endpackage

// ===== rtl/push_relabel_max_flow_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// push_relabel_max_flow_top
// Maximum flow engine: loads directed edges and solves by FIFO push-relabel.
// ----------------------------------------------------------------------------
// Usage: an item transfers on a clock edge with start high and busy low.
// in_action 0 adds edge in_from_node -> in_to_node with in_edge_capacity;
// 1 solves from in_source_node to in_sink_node. Every item gives exactly
// one result, shown for one cycle with out_valid high: out_status (0 ok,
// 1 arc table full, 2 node out of range) and out_flow_value (max flow of a
// solve, zero otherwise). The receiver cannot stall; results are not held.
// A refused item or a solve with equal ends goes from decode to its result;
// an edge add first writes both arcs; busy is high until the strobe.
// A solve first sweeps the flow and node memories, then walks the graph arc
// by arc through the arc and node memories, one read each per cycle; its
// length depends on the graph. cfg_we writes node count (clamped to 2..64);
// the user must do so while the block is idle; the block does not enforce it.
// Reset clears the graph, sets node count to 64 and leaves the block idle.
// ----------------------------------------------------------------------------
module push_relabel_max_flow_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [prmf_pkg::NC_W-1:0]     cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [prmf_pkg::NODE_AW-1:0]  in_from_node,
  input  logic [prmf_pkg::NODE_AW-1:0]  in_to_node,
  input  logic [prmf_pkg::CAP_W-1:0]    in_edge_capacity,
  input  logic [prmf_pkg::NODE_AW-1:0]  in_source_node,
  input  logic [prmf_pkg::NODE_AW-1:0]  in_sink_node,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [prmf_pkg::EXC_W-1:0]    out_flow_value
);

  prmf_pkg::dp_op_t   op;
  prmf_pkg::dp_stat_t stat;

  prmf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .op    (op)
  );

  prmf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_from_node     (in_from_node),
    .in_to_node       (in_to_node),
    .in_edge_capacity (in_edge_capacity),
    .in_source_node   (in_source_node),
    .in_sink_node     (in_sink_node),
    .op               (op),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_flow_value   (out_flow_value)
  );

endmodule

// ===== rtl/prmf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmf_dp
// Datapath: arc and node memories, active queue, discharge registers and
// result registers, driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module prmf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [prmf_pkg::NC_W-1:0]     cfg_data,
  input  logic                          in_action,
  input  logic [prmf_pkg::NODE_AW-1:0]  in_from_node,
  input  logic [prmf_pkg::NODE_AW-1:0]  in_to_node,
  input  logic [prmf_pkg::CAP_W-1:0]    in_edge_capacity,
  input  logic [prmf_pkg::NODE_AW-1:0]  in_source_node,
  input  logic [prmf_pkg::NODE_AW-1:0]  in_sink_node,
  input  prmf_pkg::dp_op_t              op,
  output prmf_pkg::dp_stat_t            stat,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [prmf_pkg::EXC_W-1:0]    out_flow_value
);

  localparam int NAW = prmf_pkg::NODE_AW;
  localparam int AAW = prmf_pkg::ARC_AW;
  localparam int ACW = prmf_pkg::ARC_CW;
  localparam int CW  = prmf_pkg::CAP_W;
  localparam int FW  = prmf_pkg::FLOW_W;
  localparam int EW  = prmf_pkg::EXC_W;
  localparam int HW  = prmf_pkg::HGT_W;
  localparam int NCW = prmf_pkg::NC_W;
  localparam int NN  = prmf_pkg::MAX_NODES;
  localparam int NA  = prmf_pkg::ARC_SLOTS;

  // memories
  logic [NAW-1:0] tgt_mem   [NA];
  logic [CW-1:0]  cap_mem   [NA];
  logic [FW-1:0]  flow_mem  [NA];
  logic [ACW-1:0] nxt_mem   [NA];
  logic [ACW-1:0] first_mem [NN];
  logic [HW-1:0]  hgt_mem   [NN];
  logic [EW-1:0]  exc_mem   [NN];
  logic [ACW-1:0] cur_mem   [NN];
  logic [NAW-1:0] q_mem     [NN];

  // read data
  logic [NAW-1:0] tgt_q;
  logic [CW-1:0]  cap_q;
  logic [FW-1:0]  flow_q;
  logic [ACW-1:0] nxt_q;
  logic [ACW-1:0] first_q;
  logic [HW-1:0]  hgt_q;
  logic [EW-1:0]  exc_q;
  logic [ACW-1:0] cur_q;
  logic [NAW-1:0] qd_q;

  // control registers
  logic [NCW-1:0] nc_r;
  logic [ACW-1:0] arc_cnt_r;
  logic [NN-1:0]  first_vld_r;
  logic [NN-1:0]  node_act_r;
  logic [NAW-1:0] q_head_r;
  logic [NAW:0]   q_len_r;
  logic           out_valid_r;

  // payload registers
  logic           act_r;
  logic [NAW-1:0] fu_r, tv_r, s_r, t_r, u_r, v_r;
  logic [CW-1:0]  cap_r;
  logic [ACW-1:0] k_r, a_r, first_r, u_cur_r;
  logic [HW-1:0]  u_hgt_r, best_r;
  logic [EW-1:0]  u_exc_r;
  logic [FW-1:0]  d_r;
  logic           found_r;
  logic [1:0]     out_status_r;
  logic [EW-1:0]  out_flow_r;

  // port controls
  logic           arc_we, arc_re, flow_we, flow_re, first_we, first_re;
  logic           hgt_we, hgt_re, exc_we, exc_re, cur_we, cur_re, q_we, q_re;
  logic [AAW-1:0] arc_wa, arc_ra, flow_wa, flow_ra;
  logic [NAW-1:0] tgt_wd, first_wa, first_ra, hgt_wa, hgt_ra, exc_wa, exc_ra;
  logic [NAW-1:0] cur_wa, cur_ra, q_wa;
  logic [CW-1:0]  cap_wd;
  logic [FW-1:0]  flow_wd;
  logic [ACW-1:0] nxt_wd, first_wd, cur_wd;
  logic [HW-1:0]  hgt_wd;
  logic [EW-1:0]  exc_wd;
  logic           enq;

  // residual and push amount
  logic [FW:0]    res;
  logic           res_pos;
  logic [FW-1:0]  d_w;
  logic [NCW-1:0] nc_clamp;

  assign res     = {2'b00, cap_q} - {flow_q[FW-1], flow_q};
  assign res_pos = ({1'b0, tgt_q} < nc_r) && !res[FW] && (res != '0);
  assign d_w     = (u_exc_r < EW'(res[FW-1:0])) ? u_exc_r[FW-1:0] : res[FW-1:0];
  assign enq     = (v_r != s_r) && (v_r != t_r) && !node_act_r[v_r];

  always_comb begin
    if (cfg_data < prmf_pkg::NC_MIN) begin
      nc_clamp = prmf_pkg::NC_MIN;
    end else if (cfg_data > prmf_pkg::NC_MAX) begin
      nc_clamp = prmf_pkg::NC_MAX;
    end else begin
      nc_clamp = cfg_data;
    end
  end

  always_comb begin
    stat.is_solve   = act_r;
    stat.bad_node   = act_r ? (({1'b0, s_r} >= nc_r) || ({1'b0, t_r} >= nc_r))
                            : (({1'b0, fu_r} >= nc_r) || ({1'b0, tv_r} >= nc_r));
    stat.table_full = arc_cnt_r > ACW'(NA - 2);
    stat.st_same    = s_r == t_r;
    stat.clr_last   = k_r == ACW'(NA);
    stat.a_end      = a_r >= arc_cnt_r;
    stat.sat_ok     = ({1'b0, tgt_q} < nc_r) && (cap_q != '0);
    stat.q_empty    = q_len_r == '0;
    stat.pop_skip   = (qd_q == s_r) || (qd_q == t_r);
    stat.exc_zero   = u_exc_r == '0;
    stat.cur_end    = u_cur_r >= arc_cnt_r;
    stat.push_ok    = res_pos && ({1'b0, u_hgt_r} == ({1'b0, hgt_q} + 9'd1));
    stat.rl_res     = res_pos;
  end

  always_comb begin
    arc_we = 1'b0; arc_re = 1'b0; flow_we = 1'b0; flow_re = 1'b0;
    first_we = 1'b0; first_re = 1'b0; hgt_we = 1'b0; hgt_re = 1'b0;
    exc_we = 1'b0; exc_re = 1'b0; cur_we = 1'b0; cur_re = 1'b0;
    q_we = 1'b0; q_re = 1'b0;
    arc_wa = arc_cnt_r[AAW-1:0]; arc_ra = a_r[AAW-1:0];
    flow_wa = a_r[AAW-1:0]; flow_ra = a_r[AAW-1:0];
    tgt_wd = tv_r; cap_wd = cap_r; nxt_wd = first_q; flow_wd = '0;
    first_wa = fu_r; first_ra = fu_r; first_wd = arc_cnt_r;
    hgt_wa = k_r[NAW-1:0]; hgt_ra = tgt_q; hgt_wd = '0;
    exc_wa = k_r[NAW-1:0]; exc_ra = tgt_q; exc_wd = '0;
    cur_wa = u_r; cur_ra = qd_q; cur_wd = u_cur_r;
    q_wa = q_head_r + q_len_r[NAW-1:0];
    unique case (op)
      prmf_pkg::OP_ADD_RDU: begin
        first_re = 1'b1;
      end
      prmf_pkg::OP_ADD_WRA: begin
        arc_we = 1'b1; flow_we = 1'b1; flow_wa = arc_cnt_r[AAW-1:0];
        first_we = 1'b1;
      end
      prmf_pkg::OP_ADD_RDV: begin
        first_re = 1'b1; first_ra = tv_r;
      end
      prmf_pkg::OP_ADD_WRB: begin
        arc_we = 1'b1; arc_wa = arc_cnt_r[AAW-1:0] + AAW'(1);
        tgt_wd = fu_r; cap_wd = '0;
        flow_we = 1'b1; flow_wa = arc_cnt_r[AAW-1:0] + AAW'(1);
        first_we = 1'b1; first_wa = tv_r; first_wd = arc_cnt_r + ACW'(1);
      end
      prmf_pkg::OP_CLR: begin
        flow_we = k_r < ACW'(NA); flow_wa = k_r[AAW-1:0];
        first_re = 1'b1; first_ra = k_r[NAW-1:0];
        cur_we = (k_r != '0) && (k_r <= ACW'(NN));
        cur_wa = NAW'(k_r - ACW'(1)); cur_wd = first_q;
        hgt_we = k_r < ACW'(NN); exc_we = k_r < ACW'(NN);
      end
      prmf_pkg::OP_SRC_H: begin
        hgt_we = 1'b1; hgt_wa = s_r; hgt_wd = HW'(nc_r);
        first_re = 1'b1; first_ra = s_r;
      end
      prmf_pkg::OP_ARC_RD: begin
        arc_re = 1'b1; flow_re = 1'b1;
      end
      prmf_pkg::OP_SRC_EVAL: begin
        flow_we = stat.sat_ok; flow_wd = FW'(cap_q);
        exc_re = 1'b1;
      end
      prmf_pkg::OP_SRC_REV: begin
        flow_we = 1'b1; flow_wa = a_r[AAW-1:0] ^ AAW'(1);
        flow_wd = FW'(0) - FW'(cap_q);
        exc_we = 1'b1; exc_wa = v_r; exc_wd = exc_q + EW'(cap_q);
        q_we = enq;
      end
      prmf_pkg::OP_POP_RD: begin
        q_re = 1'b1;
      end
      prmf_pkg::OP_POP_U: begin
        hgt_re = 1'b1; hgt_ra = qd_q; exc_re = 1'b1; exc_ra = qd_q; cur_re = 1'b1;
      end
      prmf_pkg::OP_U_DONE: begin
        exc_we = 1'b1; exc_wa = u_r; exc_wd = u_exc_r; cur_we = 1'b1;
      end
      prmf_pkg::OP_CUR_RD: begin
        arc_re = 1'b1; arc_ra = u_cur_r[AAW-1:0];
        flow_re = 1'b1; flow_ra = u_cur_r[AAW-1:0];
      end
      prmf_pkg::OP_D_H, prmf_pkg::OP_RL_H: begin
        hgt_re = 1'b1;
      end
      prmf_pkg::OP_PUSH1: begin
        flow_we = 1'b1; flow_wa = u_cur_r[AAW-1:0]; flow_wd = flow_q + d_w;
        flow_re = 1'b1; flow_ra = u_cur_r[AAW-1:0] ^ AAW'(1);
        exc_re = 1'b1; exc_ra = v_r;
      end
      prmf_pkg::OP_PUSH2: begin
        flow_we = 1'b1; flow_wa = u_cur_r[AAW-1:0] ^ AAW'(1); flow_wd = flow_q - d_r;
        exc_we = 1'b1; exc_wa = v_r; exc_wd = exc_q + EW'(d_r);
        q_we = enq;
      end
      prmf_pkg::OP_RL_FIRST: begin
        first_re = 1'b1; first_ra = u_r;
      end
      prmf_pkg::OP_RL_END: begin
        hgt_we = found_r; hgt_wa = u_r; hgt_wd = best_r + HW'(1);
      end
      prmf_pkg::OP_FIN_RD: begin
        exc_re = 1'b1; exc_ra = t_r;
      end
      default: begin
      end
    endcase
  end

  // arc memories
  always_ff @(posedge clk) begin
    if (arc_we) begin
      tgt_mem[arc_wa] <= tgt_wd;
      cap_mem[arc_wa] <= cap_wd;
      nxt_mem[arc_wa] <= nxt_wd;
    end
    if (arc_re) begin
      tgt_q <= tgt_mem[arc_ra];
      cap_q <= cap_mem[arc_ra];
      nxt_q <= nxt_mem[arc_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (flow_we) begin
      flow_mem[flow_wa] <= flow_wd;
    end
    if (flow_re) begin
      flow_q <= flow_mem[flow_ra];
    end
  end

  // node memories
  always_ff @(posedge clk) begin
    if (first_we) begin
      first_mem[first_wa] <= first_wd;
    end
    if (first_re) begin
      first_q <= first_vld_r[first_ra] ? first_mem[first_ra] : prmf_pkg::ARC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (hgt_we) begin
      hgt_mem[hgt_wa] <= hgt_wd;
    end
    if (hgt_re) begin
      hgt_q <= hgt_mem[hgt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (exc_we) begin
      exc_mem[exc_wa] <= exc_wd;
    end
    if (exc_re) begin
      exc_q <= exc_mem[exc_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_wa] <= cur_wd;
    end
    if (cur_re) begin
      cur_q <= cur_mem[cur_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= v_r;
    end
    if (q_re) begin
      qd_q <= q_mem[q_head_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r        <= prmf_pkg::NC_MAX;
      arc_cnt_r   <= '0;
      first_vld_r <= '0;
      node_act_r  <= '0;
      q_head_r    <= '0;
      q_len_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        nc_r <= nc_clamp;
      end
      if (first_we) begin
        first_vld_r[first_wa] <= 1'b1;
      end
      if (q_we) begin
        node_act_r[v_r] <= 1'b1;
        q_len_r         <= q_len_r + 7'd1;
      end
      unique case (op)
        prmf_pkg::OP_LATCH: begin
          node_act_r <= '0;
          q_head_r   <= '0;
          q_len_r    <= '0;
        end
        prmf_pkg::OP_ADD_WRB: begin
          arc_cnt_r <= arc_cnt_r + ACW'(2);
        end
        prmf_pkg::OP_POP_RD: begin
          q_head_r <= q_head_r + NAW'(1);
          q_len_r  <= q_len_r - 7'd1;
        end
        prmf_pkg::OP_POP_U: begin
          node_act_r[qd_q] <= 1'b0;
        end
        prmf_pkg::OP_OUT_OK, prmf_pkg::OP_OUT_BAD, prmf_pkg::OP_OUT_FULL,
        prmf_pkg::OP_OUT_FLOW: begin
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (op)
      prmf_pkg::OP_LATCH: begin
        act_r <= in_action;
        fu_r  <= in_from_node;
        tv_r  <= in_to_node;
        cap_r <= in_edge_capacity;
        s_r   <= in_source_node;
        t_r   <= in_sink_node;
        k_r   <= '0;
      end
      prmf_pkg::OP_CLR: begin
        k_r <= k_r + ACW'(1);
      end
      prmf_pkg::OP_LOAD_A: begin
        a_r     <= first_q;
        first_r <= first_q;
      end
      prmf_pkg::OP_SRC_EVAL, prmf_pkg::OP_D_H: begin
        v_r <= tgt_q;
      end
      prmf_pkg::OP_A_NEXT: begin
        a_r <= nxt_q;
      end
      prmf_pkg::OP_POP_U: begin
        u_r <= qd_q;
      end
      prmf_pkg::OP_LOAD_U: begin
        u_hgt_r <= hgt_q;
        u_exc_r <= exc_q;
        u_cur_r <= cur_q;
      end
      prmf_pkg::OP_PUSH1: begin
        d_r     <= d_w;
        u_exc_r <= u_exc_r - EW'(d_w);
      end
      prmf_pkg::OP_ADV: begin
        u_cur_r <= nxt_q;
      end
      prmf_pkg::OP_RL_FIRST: begin
        found_r <= 1'b0;
        best_r  <= '0;
      end
      prmf_pkg::OP_RL_EVAL: begin
        if (stat.rl_res && (!found_r || (hgt_q < best_r))) begin
          best_r <= hgt_q;
        end
        if (stat.rl_res) begin
          found_r <= 1'b1;
        end
        a_r <= nxt_q;
      end
      prmf_pkg::OP_RL_END: begin
        if (found_r) begin
          u_hgt_r <= best_r + HW'(1);
        end else begin
          u_exc_r <= '0;
        end
        u_cur_r <= first_r;
      end
      prmf_pkg::OP_OUT_OK, prmf_pkg::OP_ADD_RDU: begin
        out_status_r <= prmf_pkg::ST_OK;
        out_flow_r   <= '0;
      end
      prmf_pkg::OP_OUT_BAD: begin
        out_status_r <= prmf_pkg::ST_RANGE;
        out_flow_r   <= '0;
      end
      prmf_pkg::OP_OUT_FULL: begin
        out_status_r <= prmf_pkg::ST_FULL;
        out_flow_r   <= '0;
      end
      prmf_pkg::OP_OUT_FLOW: begin
        out_status_r <= prmf_pkg::ST_OK;
        out_flow_r   <= exc_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_flow_value = out_flow_r;

endmodule

// ===== rtl/prmf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prmf_ctrl
// Controller: sequences edge loading, solve set-up, FIFO discharge and
// relabel walks by issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module prmf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  prmf_pkg::dp_stat_t stat,
  output prmf_pkg::dp_op_t   op
);

  typedef enum logic [5:0] {
    S_IDLE, S_DECODE,
    S_ADD_RDU, S_ADD_WRA, S_ADD_RDV, S_ADD_WRB,
    S_OUT_OK, S_OUT_BAD, S_OUT_FULL, S_OUT_FLOW,
    S_CLR, S_SRC_H, S_SRC_PTR, S_SRC_CHK, S_SRC_RD, S_SRC_EVAL, S_SRC_REV, S_SRC_NX,
    S_POP, S_POP_U, S_LOAD_U, S_DIS, S_U_DONE, S_D_RD, S_D_H, S_D_EVAL, S_PUSH2,
    S_RL_START, S_RL_PTR, S_RL_CHK, S_RL_RD, S_RL_H, S_RL_EVAL, S_RL_END,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = prmf_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op = prmf_pkg::OP_LATCH; state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.bad_node) begin
          state_nxt = S_OUT_BAD;
        end else if (!stat.is_solve) begin
          state_nxt = stat.table_full ? S_OUT_FULL : S_ADD_RDU;
        end else begin
          state_nxt = stat.st_same ? S_OUT_OK : S_CLR;
        end
      end
      S_ADD_RDU:  begin op = prmf_pkg::OP_ADD_RDU;  state_nxt = S_ADD_WRA; end
      S_ADD_WRA:  begin op = prmf_pkg::OP_ADD_WRA;  state_nxt = S_ADD_RDV; end
      S_ADD_RDV:  begin op = prmf_pkg::OP_ADD_RDV;  state_nxt = S_ADD_WRB; end
      S_ADD_WRB:  begin op = prmf_pkg::OP_ADD_WRB;  state_nxt = S_OUT_OK;  end
      S_OUT_OK:   begin op = prmf_pkg::OP_OUT_OK;   state_nxt = S_IDLE;    end
      S_OUT_BAD:  begin op = prmf_pkg::OP_OUT_BAD;  state_nxt = S_IDLE;    end
      S_OUT_FULL: begin op = prmf_pkg::OP_OUT_FULL; state_nxt = S_IDLE;    end
      S_OUT_FLOW: begin op = prmf_pkg::OP_OUT_FLOW; state_nxt = S_IDLE;    end
      S_CLR: begin
        op = prmf_pkg::OP_CLR;
        if (stat.clr_last) begin
          state_nxt = S_SRC_H;
        end
      end
      S_SRC_H:   begin op = prmf_pkg::OP_SRC_H;  state_nxt = S_SRC_PTR; end
      S_SRC_PTR: begin op = prmf_pkg::OP_LOAD_A; state_nxt = S_SRC_CHK; end
      S_SRC_CHK: begin
        state_nxt = stat.a_end ? S_POP : S_SRC_RD;
      end
      S_SRC_RD:  begin op = prmf_pkg::OP_ARC_RD; state_nxt = S_SRC_EVAL; end
      S_SRC_EVAL: begin
        op = prmf_pkg::OP_SRC_EVAL;
        state_nxt = stat.sat_ok ? S_SRC_REV : S_SRC_NX;
      end
      S_SRC_REV: begin op = prmf_pkg::OP_SRC_REV; state_nxt = S_SRC_NX;  end
      S_SRC_NX:  begin op = prmf_pkg::OP_A_NEXT;  state_nxt = S_SRC_CHK; end
      S_POP: begin
        if (stat.q_empty) begin
          state_nxt = S_FIN;
        end else begin
          op = prmf_pkg::OP_POP_RD; state_nxt = S_POP_U;
        end
      end
      S_POP_U: begin
        op = prmf_pkg::OP_POP_U;
        state_nxt = stat.pop_skip ? S_POP : S_LOAD_U;
      end
      S_LOAD_U: begin op = prmf_pkg::OP_LOAD_U; state_nxt = S_DIS; end
      S_DIS: begin
        if (stat.exc_zero) begin
          state_nxt = S_U_DONE;
        end else if (stat.cur_end) begin
          state_nxt = S_RL_START;
        end else begin
          state_nxt = S_D_RD;
        end
      end
      S_U_DONE: begin op = prmf_pkg::OP_U_DONE; state_nxt = S_POP;    end
      S_D_RD:   begin op = prmf_pkg::OP_CUR_RD; state_nxt = S_D_H;    end
      S_D_H:    begin op = prmf_pkg::OP_D_H;    state_nxt = S_D_EVAL; end
      S_D_EVAL: begin
        if (stat.push_ok) begin
          op = prmf_pkg::OP_PUSH1; state_nxt = S_PUSH2;
        end else begin
          op = prmf_pkg::OP_ADV; state_nxt = S_DIS;
        end
      end
      S_PUSH2:    begin op = prmf_pkg::OP_PUSH2;    state_nxt = S_DIS;    end
      S_RL_START: begin op = prmf_pkg::OP_RL_FIRST; state_nxt = S_RL_PTR; end
      S_RL_PTR:   begin op = prmf_pkg::OP_LOAD_A;   state_nxt = S_RL_CHK; end
      S_RL_CHK: begin
        state_nxt = stat.a_end ? S_RL_END : S_RL_RD;
      end
      S_RL_RD:   begin op = prmf_pkg::OP_ARC_RD;  state_nxt = S_RL_H;    end
      S_RL_H:    begin op = prmf_pkg::OP_RL_H;    state_nxt = S_RL_EVAL; end
      S_RL_EVAL: begin op = prmf_pkg::OP_RL_EVAL; state_nxt = S_RL_CHK;  end
      S_RL_END:  begin op = prmf_pkg::OP_RL_END;  state_nxt = S_DIS;     end
      S_FIN:     begin op = prmf_pkg::OP_FIN_RD;  state_nxt = S_OUT_FLOW; end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = state_nxt != S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ===== tb/sv/push_relabel_max_flow_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// push_relabel_max_flow_top_test
// Drives edge loads and max-flow solves into the engine under several node
// counts, predicts each status and flow value with a FIFO push-relabel model
// of its own and checks every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module push_relabel_max_flow_top_test;

  localparam int         MAX_NODES = prmf_pkg::MAX_NODES;
  localparam int         NODE_AW   = prmf_pkg::NODE_AW;
  localparam int         ARC_SLOTS = prmf_pkg::ARC_SLOTS;
  localparam int         CAP_W     = prmf_pkg::CAP_W;
  localparam int         EXC_W     = prmf_pkg::EXC_W;
  localparam int         NC_W      = prmf_pkg::NC_W;
  localparam logic [NC_W-1:0] NC_MIN = prmf_pkg::NC_MIN;
  localparam logic [NC_W-1:0] NC_MAX = prmf_pkg::NC_MAX;
  localparam logic [1:0] ST_OK     = prmf_pkg::ST_OK;
  localparam logic [1:0] ST_FULL   = prmf_pkg::ST_FULL;
  localparam logic [1:0] ST_RANGE  = prmf_pkg::ST_RANGE;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_SOLVE = 1'b1;
  localparam int   NO_ARC    = ARC_SLOTS;

  typedef struct {
    logic              action;
    logic [NODE_AW-1:0] from_node;
    logic [NODE_AW-1:0] to_node;
    logic [CAP_W-1:0]   cap;
    logic [NODE_AW-1:0] src;
    logic [NODE_AW-1:0] snk;
  } flow_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [NC_W-1:0]     cfg_data = '0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_action = 1'b0;
  logic [NODE_AW-1:0]  in_from_node = '0;
  logic [NODE_AW-1:0]  in_to_node = '0;
  logic [CAP_W-1:0]    in_edge_capacity = '0;
  logic [NODE_AW-1:0]  in_source_node = '0;
  logic [NODE_AW-1:0]  in_sink_node = '0;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [EXC_W-1:0]    out_flow_value;

  push_relabel_max_flow_top DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .in_action(in_action),
    .in_from_node(in_from_node), .in_to_node(in_to_node),
    .in_edge_capacity(in_edge_capacity), .in_source_node(in_source_node),
    .in_sink_node(in_sink_node), .out_valid(out_valid),
    .out_status(out_status), .out_flow_value(out_flow_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // flow network model
  int               nodes_in_use = MAX_NODES;
  logic [NODE_AW-1:0] arc_head [ARC_SLOTS];
  logic [CAP_W-1:0]   arc_cap  [ARC_SLOTS];
  longint           arc_flw  [ARC_SLOTS];
  int               arc_link [ARC_SLOTS];
  int               arcs_used = 0;
  int               list_head [MAX_NODES];
  int               height [MAX_NODES];
  longint           excess [MAX_NODES];
  int               cur_arc [MAX_NODES];
  bit               queued [MAX_NODES];
  int               fifo [MAX_NODES];
  int               fifo_rd, fifo_len;
  longint           walk_ops;

  flow_item_t       pending [$];
  logic [1:0]       want_status [$];
  logic [EXC_W-1:0] want_flow [$];
  bit               taken = 0;
  bit               quiet = 0;
  int               errors = 0;
  longint           cycles = 0;
  longint           budget = 0;

  initial begin
    for (int i = 0; i < MAX_NODES; i++) list_head[i] = NO_ARC;
  end

  function automatic longint residual_of(int a);
    if (a >= arcs_used || int'(arc_head[a]) >= nodes_in_use) return 0;
    return longint'(arc_cap[a]) - arc_flw[a];
  endfunction

  function automatic void mark_active(int v);
    if (queued[v] || fifo_len >= MAX_NODES) return;
    queued[v] = 1;
    fifo[(fifo_rd + fifo_len) % MAX_NODES] = v;
    fifo_len++;
  endfunction

  function automatic void relabel_node(int u);
    int best;
    bit found;
    best = 0;
    found = 0;
    for (int a = list_head[u]; a < arcs_used; a = arc_link[a]) begin
      walk_ops++;
      if (residual_of(a) > 0) begin
        if (!found || height[arc_head[a]] < best) best = height[arc_head[a]];
        found = 1;
      end
    end
    if (found) height[u] = best + 1;
    else excess[u] = 0;
  endfunction

  function automatic void discharge_node(int u, int s, int t);
    int a, v;
    longint r, d;
    while (excess[u] > 0) begin
      walk_ops++;
      a = cur_arc[u];
      if (a >= arcs_used) begin
        relabel_node(u);
        cur_arc[u] = list_head[u];
      end else begin
        r = residual_of(a);
        v = arc_head[a];
        if (r > 0 && height[u] == height[v] + 1) begin
          d = (excess[u] < r) ? excess[u] : r;
          arc_flw[a] += d;
          arc_flw[a ^ 1] -= d;
          excess[u] -= (excess[u] >= d) ? d : excess[u];
          excess[v] += d;
          if (v != s && v != t) mark_active(v);
        end else begin
          cur_arc[u] = arc_link[a];
        end
      end
    end
  endfunction

  function automatic longint solve_flow(int s, int t);
    int u, v;
    for (int i = 0; i < arcs_used; i++) arc_flw[i] = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      height[i] = 0;
      excess[i] = 0;
      cur_arc[i] = list_head[i];
      queued[i] = 0;
    end
    fifo_rd = 0;
    fifo_len = 0;
    height[s] = nodes_in_use;
    for (int a = list_head[s]; a < arcs_used; a = arc_link[a]) begin
      walk_ops++;
      v = arc_head[a];
      if (v < nodes_in_use && arc_cap[a] > 0) begin
        arc_flw[a] += arc_cap[a];
        arc_flw[a ^ 1] -= arc_cap[a];
        excess[v] += arc_cap[a];
        if (v != s && v != t) mark_active(v);
      end
    end
    while (fifo_len > 0) begin
      walk_ops++;
      u = fifo[fifo_rd];
      fifo_rd = (fifo_rd + 1) % MAX_NODES;
      fifo_len--;
      queued[u] = 0;
      if (u != s && u != t) discharge_node(u, s, t);
    end
    return excess[t];
  endfunction

  function automatic void predict_result(flow_item_t it);
    logic [1:0] st;
    longint fl;
    int a;
    st = ST_OK;
    fl = 0;
    walk_ops = 0;
    if (it.action == ACT_ADD) begin
      if (it.from_node >= nodes_in_use || it.to_node >= nodes_in_use) begin
        st = ST_RANGE;
      end else if (arcs_used + 2 > ARC_SLOTS) begin
        st = ST_FULL;
      end else begin
        a = arcs_used;
        arc_head[a] = it.to_node;
        arc_cap[a] = it.cap;
        arc_flw[a] = 0;
        arc_link[a] = list_head[it.from_node];
        list_head[it.from_node] = a;
        arc_head[a + 1] = it.from_node;
        arc_cap[a + 1] = '0;
        arc_flw[a + 1] = 0;
        arc_link[a + 1] = list_head[it.to_node];
        list_head[it.to_node] = a + 1;
        arcs_used += 2;
      end
    end else begin
      if (it.src >= nodes_in_use || it.snk >= nodes_in_use) begin
        st = ST_RANGE;
      end else if (it.src != it.snk) begin
        fl = solve_flow(it.src, it.snk);
        if (fl > 64'hFFFFFF) fl = 64'hFFFFFF;
      end
      budget += 1200 + 6 * (walk_ops + arcs_used);
    end
    budget += 60;
    want_status.insert(want_status.size(), st);
    want_flow.insert(want_flow.size(), EXC_W'(fl));
  endfunction

  function automatic void add_pending(flow_item_t it);
    pending.insert(pending.size(), it);
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (taken) begin
      taken = 0;
      void'(pending.pop_front());
    end
    if (rst_n && pending.size() > 0 && (quiet || $urandom_range(0, 99) >= 37)) begin
      start <= 1'b1;
      in_action <= pending[0].action;
      in_from_node <= pending[0].from_node;
      in_to_node <= pending[0].to_node;
      in_edge_capacity <= pending[0].cap;
      in_source_node <= pending[0].src;
      in_sink_node <= pending[0].snk;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      predict_result(pending[0]);
      taken = 1;
    end
    if (rst_n && out_valid) begin
      if (want_status.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, 0);
      end else begin
        if (out_status !== want_status[0])
          report_mismatch("status", out_status, want_status[0]);
        if (out_flow_value !== want_flow[0])
          report_mismatch("flow_value", out_flow_value, want_flow[0]);
        void'(want_status.pop_front());
        void'(want_flow.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 40000 + 4 * budget) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic flow_item_t make_item(logic act, int u, int v, int c, int s, int t);
    flow_item_t it;
    it.action = act;
    it.from_node = NODE_AW'(u);
    it.to_node = NODE_AW'(v);
    it.cap = CAP_W'(c);
    it.src = NODE_AW'(s);
    it.snk = NODE_AW'(t);
    return it;
  endfunction

  function automatic int pick_node();
    if ($urandom_range(0, 99) < 8) return $urandom_range(0, MAX_NODES - 1);
    return $urandom_range(0, nodes_in_use - 1);
  endfunction

  function automatic flow_item_t random_item();
    int c;
    case ($urandom_range(0, 3))
      0: c = $urandom_range(0, 65535);
      1: c = $urandom_range(1, 20);
      2: c = 65535;
      default: c = $urandom_range(0, 1) ? 0 : $urandom_range(1000, 40000);
    endcase
    return make_item($urandom_range(0, 99) < 5 ? ACT_SOLVE : ACT_ADD,
                     pick_node(), pick_node(), c, pick_node(), pick_node());
  endfunction

  task automatic drain();
    wait (pending.size() == 0 && want_status.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_node_count(logic [NC_W-1:0] value);
    int v;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    v = value;
    if (v < NC_MIN) v = NC_MIN;
    if (v > NC_MAX) v = NC_MAX;
    nodes_in_use = v;
  endtask

  initial begin
    logic [NC_W-1:0] settings [6];
    settings = '{7'd127, 7'd0, 7'd13, 7'd5, 7'd40, 7'd64};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_node_count(7'd64);
    add_pending(make_item(ACT_ADD, 0, 63, 65535, 0, 0));
    add_pending(make_item(ACT_ADD, 63, 0, 0, 63, 63));
    add_pending(make_item(ACT_ADD, 0, 1, 1, 0, 0));
    add_pending(make_item(ACT_ADD, 1, 63, 40000, 0, 0));
    add_pending(make_item(ACT_ADD, 5, 5, 100, 0, 0));
    add_pending(make_item(ACT_ADD, 0, 5, 7, 0, 0));
    add_pending(make_item(ACT_SOLVE, 0, 0, 0, 0, 63));
    add_pending(make_item(ACT_SOLVE, 0, 0, 0, 63, 0));
    add_pending(make_item(ACT_SOLVE, 0, 0, 0, 7, 7));
    add_pending(make_item(ACT_SOLVE, 0, 0, 0, 5, 63));
    drain();
    write_node_count(7'd1);
    add_pending(make_item(ACT_ADD, 0, 1, 5, 0, 0));
    add_pending(make_item(ACT_ADD, 3, 1, 5, 0, 0));
    add_pending(make_item(ACT_ADD, 1, 63, 5, 0, 0));
    add_pending(make_item(ACT_SOLVE, 0, 0, 0, 0, 1));
    add_pending(make_item(ACT_SOLVE, 0, 0, 0, 1, 0));
    add_pending(make_item(ACT_SOLVE, 0, 0, 0, 0, 2));
    add_pending(make_item(ACT_SOLVE, 0, 0, 0, 63, 1));
    drain();
    for (int p = 0; p < 8; p++) begin
      write_node_count(p < 6 ? settings[p] : NC_W'($urandom_range(2, 64)));
      quiet = (p == 2);
      for (int i = 0; i < 165; i++) add_pending(random_item());
      drain();
    end
    quiet = 0;
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
